// ----- rtl/fsp_pkg.sv -----
`default_nettype none

package fsp_pkg;

  localparam int PIECE_KINDS  = 12;
  localparam int COUNTER_BITS = 16;
  localparam int SLOT_BITS    = 4;
  localparam int SQUARES      = 64;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_W     = 8'h77;

  localparam logic [7:0] CH_LP = 8'h70;
  localparam logic [7:0] CH_LN = 8'h6E;
  localparam logic [7:0] CH_LB = 8'h62;
  localparam logic [7:0] CH_LR = 8'h72;
  localparam logic [7:0] CH_LQ = 8'h71;
  localparam logic [7:0] CH_LK = 8'h6B;
  localparam logic [7:0] CH_UP = 8'h50;
  localparam logic [7:0] CH_UN = 8'h4E;
  localparam logic [7:0] CH_UB = 8'h42;
  localparam logic [7:0] CH_UR = 8'h52;
  localparam logic [7:0] CH_UQ = 8'h51;
  localparam logic [7:0] CH_UK = 8'h4B;

  localparam logic [3:0] CASTLE_WK = 4'h1;
  localparam logic [3:0] CASTLE_WQ = 4'h2;
  localparam logic [3:0] CASTLE_BK = 4'h4;
  localparam logic [3:0] CASTLE_BQ = 4'h8;

  localparam logic [6:0] NO_PASSANT = 7'd64;
  localparam logic [3:0] RANK_TOP   = 4'd7;
  localparam logic [3:0] RANK_OFF   = 4'd15;
  localparam logic [6:0] FILE_MAX   = 7'd127;

  typedef enum logic [3:0] {
    PH_PLACE    = 4'd0,
    PH_SIDE     = 4'd1,
    PH_SKIP     = 4'd2,
    PH_CASTLE   = 4'd3,
    PH_EP1      = 4'd4,
    PH_EP2      = 4'd5,
    PH_EPSEP    = 4'd6,
    PH_HALF     = 4'd7,
    PH_HALFSKIP = 4'd8,
    PH_FULL     = 4'd9,
    PH_STOP     = 4'd10
  } phase_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_EARLY     = 3'd1,
    ST_BAD_PIECE = 3'd2,
    ST_BAD_EP    = 3'd3,
    ST_OFF_BOARD = 3'd4
  } status_e;

  typedef enum logic {
    KIND_BOARD   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic                 item_kind;
    logic [SLOT_BITS-1:0] piece_slot;
    logic [63:0]          occupancy;
    logic                 white_to_move;
    logic [3:0]           castle_flags;
    logic [6:0]           passant_square;
    logic [15:0]          halfmove_count;
    logic [15:0]          fullmove_count;
    logic [2:0]           parse_status;
    logic                 final_item;
  } out_item_t;

  typedef logic [PIECE_KINDS-1:0][SQUARES-1:0] board_arr_t;

  typedef struct packed {
    logic        side;
    logic [3:0]  castle;
    logic [6:0]  passant;
    logic [15:0] halfmove;
    logic [15:0] fullmove;
    status_e     status;
  } summary_t;

  typedef struct packed {
    logic                 ok;
    logic [SLOT_BITS-1:0] slot;
  } slot_t;

  function automatic slot_t letter_slot(logic [7:0] ch);
    slot_t r;
    r.ok = 1'b1;
    case (ch)
      CH_LP:   r.slot = 4'd0;
      CH_LN:   r.slot = 4'd1;
      CH_LB:   r.slot = 4'd2;
      CH_LR:   r.slot = 4'd3;
      CH_LQ:   r.slot = 4'd4;
      CH_LK:   r.slot = 4'd5;
      CH_UP:   r.slot = 4'd6;
      CH_UN:   r.slot = 4'd7;
      CH_UB:   r.slot = 4'd8;
      CH_UR:   r.slot = 4'd9;
      CH_UQ:   r.slot = 4'd10;
      CH_UK:   r.slot = 4'd11;
      default: begin
        r.ok   = 1'b0;
        r.slot = 4'd0;
      end
    endcase
    return r;
  endfunction

  // saturating v*10 + d
  function automatic logic [COUNTER_BITS-1:0] count_digit(logic [COUNTER_BITS-1:0] v,
                                                          logic [3:0] d);
    logic [COUNTER_BITS+3:0] n;
    n = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{COUNTER_BITS{1'b0}}, d};
    if (n > {4'b0, {COUNTER_BITS{1'b1}}}) begin
      return {COUNTER_BITS{1'b1}};
    end
    return n[COUNTER_BITS-1:0];
  endfunction

  function automatic logic [15:0] to_field(logic [COUNTER_BITS-1:0] v);
    logic [COUNTER_BITS+15:0] ext;
    ext = {16'b0, v};
    return ext[15:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/fsp_parser.sv -----
`default_nettype none

module fsp_parser import fsp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire in_item_t   in_i,
  output board_arr_t      boards_o,
  output summary_t        sum_o
);

  board_arr_t              boards_q, boards_d;
  phase_e                  phase_q, phase_d;
  logic [3:0]              rank_q, rank_d;
  logic [6:0]              file_q, file_d;
  logic [7:0]              ep_first_q, ep_first_d;
  logic                    side_q, side_d;
  logic [3:0]              castle_q, castle_d;
  logic [6:0]              ep_q, ep_d;
  logic [COUNTER_BITS-1:0] half_q, half_d;
  logic [COUNTER_BITS-1:0] full_q, full_d;
  status_e                 status_q, status_d;

  logic [7:0] ch;
  logic       is_digit;
  logic [3:0] digit;
  logic [7:0] ch_off;
  logic [7:0] first_off;
  logic [7:0] file_sum;
  slot_t      ls;
  logic [5:0] sq;

  assign ch        = in_i.text_byte;
  assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign digit     = 4'(ch - CH_ZERO);
  assign ch_off    = ch - CH_ONE;
  assign first_off = ep_first_q - CH_A;
  assign file_sum  = {1'b0, file_q} + {4'b0, digit};
  assign ls        = letter_slot(ch);
  assign sq        = {rank_q[2:0], file_q[2:0]};

  always_comb begin
    boards_d   = boards_q;
    phase_d    = phase_q;
    rank_d     = rank_q;
    file_d     = file_q;
    ep_first_d = ep_first_q;
    side_d     = side_q;
    castle_d   = castle_q;
    ep_d       = ep_q;
    half_d     = half_q;
    full_d     = full_q;
    status_d   = status_q;
    if (phase_q == PH_STOP) begin
      phase_d = PH_STOP;
    end else if (ch == CH_NUL) begin
      phase_d = PH_STOP;
    end else begin
      unique case (phase_q)
        PH_PLACE: begin
          if (ch == CH_SPACE) begin
            phase_d = PH_SIDE;
          end else if (ch == CH_SLASH) begin
            rank_d = (rank_q == 4'd0 || rank_q > RANK_TOP) ? RANK_OFF : rank_q - 4'd1;
            file_d = 7'd0;
          end else if (is_digit) begin
            file_d = (file_sum > {1'b0, FILE_MAX}) ? FILE_MAX : file_sum[6:0];
          end else if (!ls.ok) begin
            status_d = ST_BAD_PIECE;
            phase_d  = PH_STOP;
          end else if (rank_q > RANK_TOP || file_q > 7'd7) begin
            status_d = ST_OFF_BOARD;
            phase_d  = PH_STOP;
          end else begin
            boards_d[ls.slot] = boards_q[ls.slot] | (64'd1 << sq);
            file_d = file_q + 7'd1;
          end
        end
        PH_SIDE: begin
          side_d  = (ch == CH_W);
          phase_d = PH_SKIP;
        end
        PH_SKIP: begin
          phase_d = PH_CASTLE;
        end
        PH_CASTLE: begin
          if (ch == CH_SPACE) begin
            phase_d = PH_EP1;
          end else if (ch == CH_UK) begin
            castle_d = castle_q | CASTLE_WK;
          end else if (ch == CH_UQ) begin
            castle_d = castle_q | CASTLE_WQ;
          end else if (ch == CH_LK) begin
            castle_d = castle_q | CASTLE_BK;
          end else if (ch == CH_LQ) begin
            castle_d = castle_q | CASTLE_BQ;
          end
        end
        PH_EP1: begin
          if (ch == CH_DASH) begin
            ep_d    = NO_PASSANT;
            phase_d = PH_EPSEP;
          end else begin
            ep_first_d = ch;
            phase_d    = PH_EP2;
          end
        end
        PH_EP2: begin
          if (ep_first_q < CH_A || ep_first_q > CH_H || ch < CH_ONE || ch > CH_EIGHT) begin
            status_d = ST_BAD_EP;
            phase_d  = PH_STOP;
          end else begin
            ep_d    = {1'b0, ch_off[2:0], first_off[2:0]};
            phase_d = PH_EPSEP;
          end
        end
        PH_EPSEP: begin
          if (ch != CH_SPACE) begin
            status_d = ST_EARLY;
            phase_d  = PH_STOP;
          end else begin
            phase_d = PH_HALF;
          end
        end
        PH_HALF: begin
          if (is_digit) begin
            half_d = count_digit(half_q, digit);
          end else if (ch == CH_SPACE) begin
            phase_d  = PH_FULL;
            status_d = ST_DONE;
          end else begin
            phase_d = PH_HALFSKIP;
          end
        end
        PH_HALFSKIP: begin
          if (ch == CH_SPACE) begin
            phase_d  = PH_FULL;
            status_d = ST_DONE;
          end
        end
        PH_FULL: begin
          if (is_digit) begin
            full_d = count_digit(full_q, digit);
          end else begin
            phase_d = PH_STOP;
          end
        end
        default: begin
          phase_d = PH_STOP;
        end
      endcase
    end
  end

  assign boards_o         = boards_d;
  assign sum_o.side       = side_d;
  assign sum_o.castle     = castle_d;
  assign sum_o.passant    = ep_d;
  assign sum_o.halfmove   = to_field(half_d);
  assign sum_o.fullmove   = to_field(full_d);
  assign sum_o.status     = status_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boards_q   <= '0;
      phase_q    <= PH_PLACE;
      rank_q     <= RANK_TOP;
      file_q     <= '0;
      ep_first_q <= '0;
      side_q     <= 1'b0;
      castle_q   <= '0;
      ep_q       <= '0;
      half_q     <= '0;
      full_q     <= '0;
      status_q   <= ST_EARLY;
    end else if (accept_i) begin
      if (in_i.last_byte) begin
        boards_q   <= '0;
        phase_q    <= PH_PLACE;
        rank_q     <= RANK_TOP;
        file_q     <= '0;
        ep_first_q <= '0;
        side_q     <= 1'b0;
        castle_q   <= '0;
        ep_q       <= '0;
        half_q     <= '0;
        full_q     <= '0;
        status_q   <= ST_EARLY;
      end else begin
        boards_q   <= boards_d;
        phase_q    <= phase_d;
        rank_q     <= rank_d;
        file_q     <= file_d;
        ep_first_q <= ep_first_d;
        side_q     <= side_d;
        castle_q   <= castle_d;
        ep_q       <= ep_d;
        half_q     <= half_d;
        full_q     <= full_d;
        status_q   <= status_d;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fsp_emitter.sv -----
`default_nettype none

module fsp_emitter import fsp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  wire board_arr_t boards_i,
  input  wire summary_t   sum_i,
  output logic            busy_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output out_item_t       out_data_o
);

  board_arr_t           boards_q;
  summary_t             sum_q;
  logic [SLOT_BITS-1:0] idx_q, idx_d;
  logic                 busy_q, busy_d;
  logic                 is_sum;
  logic                 take;

  assign is_sum = (idx_q == SLOT_BITS'(PIECE_KINDS));
  assign take   = busy_q && !out_stall_i;

  always_comb begin
    idx_d  = idx_q;
    busy_d = busy_q;
    if (load_i) begin
      idx_d  = '0;
      busy_d = 1'b1;
    end else if (take) begin
      if (is_sum) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + SLOT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      boards_q <= boards_i;
      sum_q    <= sum_i;
    end
  end

  always_comb begin
    out_data_o = '0;
    if (is_sum) begin
      out_data_o.item_kind      = KIND_SUMMARY;
      out_data_o.white_to_move  = sum_q.side;
      out_data_o.castle_flags   = sum_q.castle;
      out_data_o.passant_square = sum_q.passant;
      out_data_o.halfmove_count = sum_q.halfmove;
      out_data_o.fullmove_count = sum_q.fullmove;
      out_data_o.parse_status   = sum_q.status;
      out_data_o.final_item     = 1'b1;
    end else begin
      out_data_o.item_kind  = KIND_BOARD;
      out_data_o.piece_slot = idx_q;
      if (idx_q < SLOT_BITS'(PIECE_KINDS)) begin
        out_data_o.occupancy = boards_q[idx_q];
      end
    end
  end

  assign busy_o      = busy_q;
  assign out_valid_o = busy_q;

endmodule

`default_nettype wire

// ----- rtl/fen_string_parser_core.sv -----
`default_nettype none

// Position text parser: takes one character per cycle while in_stall_o is low
// and updates the twelve piece boards and the side, castling, en passant and
// counter fields as it goes. The byte flagged last_byte is parsed, then a burst
// of thirteen transactions is sent: twelve occupancy words (slot 0 to 11) and one
// summary with final_item set, one per cycle while out_stall_i is low. Plain bytes
// of the next text are taken every cycle during a burst; a last byte is held off
// (in_stall_o high) until the current burst has left and the emitter has gone
// idle, so only one burst is pending at a time on the single output port.
module fen_string_parser_core import fsp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_item_t     out_data_o
);

  logic       accept;
  logic       load;
  logic       busy;
  board_arr_t boards;
  summary_t   sum;

  assign in_stall_o = busy && in_data_i.last_byte;
  assign accept     = in_valid_i && !in_stall_o;
  assign load       = accept && in_data_i.last_byte;

  fsp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_data_i),
    .boards_o (boards),
    .sum_o    (sum)
  );

  fsp_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .boards_i    (boards),
    .sum_i       (sum),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_burst_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (out_valid_o && out_data_o.item_kind == KIND_BOARD &&
              out_data_o.piece_slot == '0))
    else $error("burst did not start at slot zero");

  a_final_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.final_item == out_data_o.item_kind))
    else $error("final_item and item_kind disagree");

  a_burst_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.final_item) |=> !out_valid_o)
    else $error("transaction after summary");

  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !out_valid_o)
    else $error("new burst loaded over a pending one");

endmodule

`default_nettype wire

// ----- tb/sv/tb_fen_string_parser_core.sv -----
`timescale 1ns / 1ps

module tb_fen_string_parser_core;
  import fsp_pkg::*;

  localparam int    MAX_CYCLES     = 200000;
  localparam int    RANDOM_BYTES   = 400;
  localparam int    SETTLE_CYCLES  = 20;
  localparam int    MAX_REPORTS    = 60;
  localparam string PIECE_LETTERS  = "pnbrqkPNBRQK";
  localparam string CASTLE_LETTERS = "KQkq";

  typedef struct {
    string    text;
    bit       nul_end;
    bit       typed;
    summary_t sum;
  } text_case_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // position predictor
  logic [63:0] pos_boards [PIECE_KINDS];
  phase_e      pos_phase;
  logic [3:0]  pos_rank;
  logic [6:0]  pos_file;
  logic [7:0]  pos_ep_file;
  summary_t    pos_sum;

  out_item_t   position_items_q [$];
  logic [7:0]  text_q [$];
  bit          use_typed;
  summary_t    typed_sum;
  out_item_t   want_item;
  int          mismatches = 0;
  int          burst_left;
  int          bytes_sent;
  int          cycles = 0;
  int          stall_mode = 0;
  int          stall_left = 0;

  text_case_t directed_cases [5] = '{
    '{"", 1'b1, 1'b1, '{1'b0, 4'h0, 7'd0, 16'd0, 16'd0, ST_EARLY}},
    '{"x", 1'b0, 1'b1, '{1'b0, 4'h0, 7'd0, 16'd0, 16'd0, ST_BAD_PIECE}},
    '{"8p", 1'b0, 1'b1, '{1'b0, 4'h0, 7'd0, 16'd0, 16'd0, ST_OFF_BOARD}},
    '{"8 w KQkq i9", 1'b0, 1'b1,
      '{1'b1, CASTLE_WK | CASTLE_WQ | CASTLE_BK | CASTLE_BQ, 7'd0, 16'd0, 16'd0,
        ST_BAD_EP}},
    '{"K b Qk h8 99999 ", 1'b1, 1'b0, '0}
  };

  always #5 clk = ~clk;

  fen_string_parser_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  function automatic void clear_position();
    foreach (pos_boards[k]) pos_boards[k] = '0;
    pos_phase      = PH_PLACE;
    pos_rank       = RANK_TOP;
    pos_file       = '0;
    pos_ep_file    = '0;
    pos_sum        = '0;
    pos_sum.status = ST_EARLY;
  endfunction

  function automatic int slot_of_letter(logic [7:0] ch);
    for (int k = 0; k < PIECE_KINDS; k++) begin
      if (PIECE_LETTERS[k] == ch) return k;
    end
    return -1;
  endfunction

  function automatic logic [15:0] next_count(logic [15:0] v, logic [7:0] ch);
    longint unsigned n;
    longint unsigned top;
    top = (64'd1 << COUNTER_BITS) - 64'd1;
    n   = 64'(v) * 64'd10 + 64'(ch - CH_ZERO);
    if (n > top) n = top;
    return n[15:0];
  endfunction

  function automatic void halt_parse(status_e code);
    pos_sum.status = code;
    pos_phase      = PH_STOP;
  endfunction

  function automatic void parse_char(logic [7:0] ch);
    logic is_digit;
    int   slot;
    int   f;
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    if (pos_phase >= PH_STOP) return;
    if (ch == CH_NUL) begin
      pos_phase = PH_STOP;
      return;
    end
    case (pos_phase)
      PH_PLACE: begin
        if (ch == CH_SPACE) begin
          pos_phase = PH_SIDE;
        end else if (ch == CH_SLASH) begin
          pos_rank = (pos_rank == 4'd0 || pos_rank > RANK_TOP) ? RANK_OFF : pos_rank - 4'd1;
          pos_file = '0;
        end else if (is_digit) begin
          f        = int'(pos_file) + int'(ch - CH_ZERO);
          pos_file = (f > int'(FILE_MAX)) ? FILE_MAX : 7'(f);
        end else begin
          slot = slot_of_letter(ch);
          if (slot < 0) begin
            halt_parse(ST_BAD_PIECE);
          end else if (pos_rank > RANK_TOP || pos_file > 7'd7) begin
            halt_parse(ST_OFF_BOARD);
          end else begin
            pos_boards[slot][{pos_rank[2:0], pos_file[2:0]}] = 1'b1;
            pos_file = pos_file + 7'd1;
          end
        end
      end
      PH_SIDE: begin
        pos_sum.side = (ch == CH_W);
        pos_phase    = PH_SKIP;
      end
      PH_SKIP: pos_phase = PH_CASTLE;
      PH_CASTLE: begin
        if (ch == CH_SPACE) pos_phase = PH_EP1;
        else if (ch == CH_UK) pos_sum.castle |= CASTLE_WK;
        else if (ch == CH_UQ) pos_sum.castle |= CASTLE_WQ;
        else if (ch == CH_LK) pos_sum.castle |= CASTLE_BK;
        else if (ch == CH_LQ) pos_sum.castle |= CASTLE_BQ;
      end
      PH_EP1: begin
        if (ch == CH_DASH) begin
          pos_sum.passant = NO_PASSANT;
          pos_phase       = PH_EPSEP;
        end else begin
          pos_ep_file = ch;
          pos_phase   = PH_EP2;
        end
      end
      PH_EP2: begin
        if (pos_ep_file < CH_A || pos_ep_file > CH_H || ch < CH_ONE || ch > CH_EIGHT) begin
          halt_parse(ST_BAD_EP);
        end else begin
          pos_sum.passant = 7'((ch - CH_ONE) * 8'd8 + (pos_ep_file - CH_A));
          pos_phase       = PH_EPSEP;
        end
      end
      PH_EPSEP: begin
        if (ch != CH_SPACE) halt_parse(ST_EARLY);
        else pos_phase = PH_HALF;
      end
      PH_HALF: begin
        if (is_digit) begin
          pos_sum.halfmove = next_count(pos_sum.halfmove, ch);
        end else if (ch == CH_SPACE) begin
          pos_phase      = PH_FULL;
          pos_sum.status = ST_DONE;
        end else begin
          pos_phase = PH_HALFSKIP;
        end
      end
      PH_HALFSKIP: begin
        if (ch == CH_SPACE) begin
          pos_phase      = PH_FULL;
          pos_sum.status = ST_DONE;
        end
      end
      PH_FULL: begin
        if (is_digit) pos_sum.fullmove = next_count(pos_sum.fullmove, ch);
        else pos_phase = PH_STOP;
      end
      default: ;
    endcase
  endfunction

  function automatic void emit_position();
    out_item_t it;
    summary_t  s;
    for (int k = 0; k < PIECE_KINDS; k++) begin
      it            = '0;
      it.item_kind  = KIND_BOARD;
      it.piece_slot = SLOT_BITS'(k);
      it.occupancy  = use_typed ? 64'd0 : pos_boards[k];
      position_items_q.push_back(it);
    end
    s                 = use_typed ? typed_sum : pos_sum;
    it                = '0;
    it.item_kind      = KIND_SUMMARY;
    it.white_to_move  = s.side;
    it.castle_flags   = s.castle;
    it.passant_square = s.passant;
    it.halfmove_count = s.halfmove;
    it.fullmove_count = s.fullmove;
    it.parse_status   = s.status;
    it.final_item     = 1'b1;
    position_items_q.push_back(it);
    clear_position();
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void put_digits(int count, bit nines);
    for (int i = 0; i < count; i++)
      text_q.push_back(nines ? CH_NINE : 8'(CH_ZERO + 8'($urandom_range(0, 9))));
  endfunction

  function automatic void put_counter();
    int shape;
    shape = $urandom_range(0, 9);
    if (shape == 0) text_q.push_back($urandom_range(0, 1) ? 8'h2B : CH_DASH);
    if (shape == 1) put_digits(5, 1'b1);
    else if (shape == 2) put_digits(6, 1'b0);
    else put_digits($urandom_range(0, 3), 1'b0);
    if ($urandom_range(0, 19) == 0) text_q.push_back(8'($urandom_range(33, 126)));
  endfunction

  function automatic void build_random_text();
    int shape;
    int ranks;
    int f;
    int d;
    int cut;
    text_q.delete();
    shape = $urandom_range(0, 19);
    if (shape < 3) begin
      repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
      if (shape == 0) text_q.push_back(CH_NUL);
      return;
    end
    ranks = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 10) : 8;
    for (int r = 0; r < ranks; r++) begin
      if (r != 0) text_q.push_back(CH_SLASH);
      f = 0;
      while (f < 8) begin
        if ($urandom_range(0, 4) == 0) begin
          text_q.push_back(PIECE_LETTERS[$urandom_range(0, PIECE_KINDS - 1)]);
          f++;
        end else begin
          d = $urandom_range(1, 8 - f);
          text_q.push_back(8'(CH_ZERO + 8'(d)));
          f += d;
        end
      end
      if ($urandom_range(0, 59) == 0) put_digits(15, 1'b1);
      if ($urandom_range(0, 59) == 0)
        text_q.push_back(PIECE_LETTERS[$urandom_range(0, PIECE_KINDS - 1)]);
    end
    text_q.push_back(CH_SPACE);
    case ($urandom_range(0, 9))
      0:       text_q.push_back(8'($urandom_range(0, 255)));
      1, 2, 3, 4, 5: text_q.push_back(CH_W);
      default: text_q.push_back(CH_LB);
    endcase
    text_q.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : CH_SPACE);
    if ($urandom_range(0, 2) == 0) begin
      text_q.push_back(CH_DASH);
    end else begin
      repeat ($urandom_range(1, 5)) text_q.push_back(CASTLE_LETTERS[$urandom_range(0, 3)]);
    end
    text_q.push_back(CH_SPACE);
    if ($urandom_range(0, 2) == 0) begin
      text_q.push_back(CH_DASH);
    end else begin
      text_q.push_back(($urandom_range(0, 6) == 0) ? 8'($urandom_range(33, 126))
                                                   : 8'(CH_A + 8'($urandom_range(0, 7))));
      text_q.push_back(($urandom_range(0, 6) == 0) ? 8'($urandom_range(33, 126))
                                                   : 8'(CH_ONE + 8'($urandom_range(0, 7))));
    end
    text_q.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(33, 126)) : CH_SPACE);
    put_counter();
    text_q.push_back(CH_SPACE);
    put_counter();
    case ($urandom_range(0, 9))
      0: text_q.push_back(CH_NUL);
      1: text_q.push_back(8'($urandom_range(0, 255)));
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) begin
      cut    = $urandom_range(1, text_q.size());
      text_q = text_q[0:cut-1];
    end
    if ($urandom_range(0, 9) == 0)
      text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(logic [7:0] ch, logic last);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 10);
    end
    in_valid <= 1'b1;
    in_data  <= '{text_byte: ch, last_byte: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_char(ch);
    if (last) emit_position();
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (position_items_q.size() != 0);
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 60);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= ((stall_left % 8) < 5);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (position_items_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected output transaction, expected none actual %p", $time,
                   out_data);
      end else begin
        want_item = position_items_q.pop_front();
        check_field("item_kind", 64'(want_item.item_kind), 64'(out_data.item_kind));
        check_field("piece_slot", 64'(want_item.piece_slot), 64'(out_data.piece_slot));
        check_field("occupancy", want_item.occupancy, out_data.occupancy);
        check_field("white_to_move", 64'(want_item.white_to_move),
                    64'(out_data.white_to_move));
        check_field("castle_flags", 64'(want_item.castle_flags), 64'(out_data.castle_flags));
        check_field("passant_square", 64'(want_item.passant_square),
                    64'(out_data.passant_square));
        check_field("halfmove_count", 64'(want_item.halfmove_count),
                    64'(out_data.halfmove_count));
        check_field("fullmove_count", 64'(want_item.fullmove_count),
                    64'(out_data.fullmove_count));
        check_field("parse_status", 64'(want_item.parse_status), 64'(out_data.parse_status));
        check_field("final_item", 64'(want_item.final_item), 64'(out_data.final_item));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("fen_string_parser_core verification failed");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    burst_left = 0;
    bytes_sent = 0;
    use_typed  = 1'b0;
    typed_sum  = '0;
    clear_position();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_cases[i]) begin
      use_typed = directed_cases[i].typed;
      typed_sum = directed_cases[i].sum;
      text_q.delete();
      put_text(directed_cases[i].text);
      if (directed_cases[i].nul_end) text_q.push_back(CH_NUL);
      send_text();
    end
    use_typed = 1'b0;
    wait_drained();

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      build_random_text();
      send_text();
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("fen_string_parser_core verification clean");
    end else begin
      $display("fen_string_parser_core verification failed");
    end
    $finish;
  end

endmodule
